FILE: rtl/gcrf_pkg.sv
// shared types, register numbers and helper functions of the geometry
// coprocessor register file; no dependencies
package gcrf_pkg;

    typedef logic [31:0] t_word;
    typedef logic [15:0] t_half;
    typedef logic [1:0]  t_mode;
    typedef logic [4:0]  t_idx;

    localparam int LEAD_W = 6;

    // access modes
    localparam t_mode MODE_DATA_RD = 2'd0;
    localparam t_mode MODE_DATA_WR = 2'd1;
    localparam t_mode MODE_CTRL_RD = 2'd2;
    localparam t_mode MODE_CTRL_WR = 2'd3;

    // data bank
    localparam t_idx DR_VXY0 = 5'd0;
    localparam t_idx DR_VZ0  = 5'd1;
    localparam t_idx DR_VXY1 = 5'd2;
    localparam t_idx DR_VZ1  = 5'd3;
    localparam t_idx DR_VXY2 = 5'd4;
    localparam t_idx DR_VZ2  = 5'd5;
    localparam t_idx DR_RGBC = 5'd6;
    localparam t_idx DR_OTZ  = 5'd7;
    localparam t_idx DR_IR0  = 5'd8;
    localparam t_idx DR_IR1  = 5'd9;
    localparam t_idx DR_IR2  = 5'd10;
    localparam t_idx DR_IR3  = 5'd11;
    localparam t_idx DR_SXY0 = 5'd12;
    localparam t_idx DR_SXY1 = 5'd13;
    localparam t_idx DR_SXY2 = 5'd14;
    localparam t_idx DR_SXYP = 5'd15;
    localparam t_idx DR_SZ0  = 5'd16;
    localparam t_idx DR_SZ1  = 5'd17;
    localparam t_idx DR_SZ2  = 5'd18;
    localparam t_idx DR_SZ3  = 5'd19;
    localparam t_idx DR_RGB0 = 5'd20;
    localparam t_idx DR_RGB1 = 5'd21;
    localparam t_idx DR_RGB2 = 5'd22;
    localparam t_idx DR_RES1 = 5'd23;
    localparam t_idx DR_MAC0 = 5'd24;
    localparam t_idx DR_MAC1 = 5'd25;
    localparam t_idx DR_MAC2 = 5'd26;
    localparam t_idx DR_MAC3 = 5'd27;
    localparam t_idx DR_IRGB = 5'd28;
    localparam t_idx DR_ORGB = 5'd29;
    localparam t_idx DR_LZCS = 5'd30;
    localparam t_idx DR_LZCR = 5'd31;

    // control bank, upper scalar group
    localparam t_idx CR_OFX  = 5'd24;
    localparam t_idx CR_OFY  = 5'd25;
    localparam t_idx CR_H    = 5'd26;
    localparam t_idx CR_DQA  = 5'd27;
    localparam t_idx CR_DQB  = 5'd28;
    localparam t_idx CR_ZSF3 = 5'd29;
    localparam t_idx CR_ZSF4 = 5'd30;
    localparam t_idx CR_FLAG = 5'd31;

    // control bank, matrix groups of eight words
    localparam logic [1:0] GROUP_SCALAR    = 2'd3;
    localparam logic [2:0] MAT_SINGLE_WORD = 3'd4;
    localparam logic [2:0] VEC_FIRST_WORD  = 3'd5;

    localparam t_word FLAG_KEEP_MASK  = 32'h7FFF_F000;
    localparam t_word FLAG_ERROR_MASK = 32'h7F87_E000;
    localparam t_word FLAG_ERROR_BIT  = 32'h8000_0000;
    localparam logic [4:0] COLOR_FIELD_MAX = 5'h1F;

    function automatic t_word sext16(input t_half x);
        return {{16{x[15]}}, x};
    endfunction

    // signed ir / 128 toward zero, clamped to 0..31
    function automatic logic [4:0] color_field(input t_half ir);
        logic [4:0] f;
        if (ir[15]) begin
            f = '0;
        end else if (ir[14:12] != 3'd0) begin
            f = COLOR_FIELD_MAX;
        end else begin
            f = ir[11:7];
        end
        return f;
    endfunction

    // field times 128 as a 16-bit ir value
    function automatic t_half color_expand(input logic [4:0] f);
        return {4'd0, f, 7'd0};
    endfunction

endpackage

FILE: rtl/geometry_coprocessor_register_file_top.sv
// register file of the geometry coprocessor: data and control banks with
// side effects; depends on gcrf_pkg and gcrf_lzc
//
// One access (a read or write of one data or control register) is taken per
// transfer on the input channel, and a new transfer can be taken in every
// cycle while o_stall is low. Each access passes through one input register;
// from there a write updates the register bank at the next edge and a read
// loads the output register, which drives read data on o_read_value with
// o_valid asserted. Writes give no output transfer. Accesses act in transfer
// order, so a read always sees every earlier write. The sustained rate is one
// access per cycle, set by the single input-register to output-register pass;
// it drops only while a read waits behind a stalled output. Side effects of
// data writes: register 15 pushes the screen xy fifo, register 28 loads
// ir1..ir3 from the packed 5-bit colors, register 30 updates the
// leading-count result. Control register 31 (flag) keeps bits 30..12 and
// derives its summary bit 31. Banks and valid bits clear on reset.
module geometry_coprocessor_register_file_top
    import gcrf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    // access channel
    input  logic  i_valid,
    output logic  o_stall,
    input  t_mode i_mode,
    input  t_idx  i_reg_index,
    input  t_word i_write_value,
    // read data channel
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_read_value
);

    // input register
    logic  r_in_valid;
    t_mode r_mode;
    t_idx  r_idx;
    t_word r_val;

    // output register
    logic  r_out_valid;
    t_word r_out_data;

    // data bank
    t_word r_vxy [3];
    t_half r_vz  [3];
    t_word r_rgbc;
    t_half r_otz;
    t_half r_ir  [4];
    t_word r_sxy [3];
    t_half r_sz  [4];
    t_word r_rgb [3];
    t_word r_res1;
    t_word r_mac [4];
    logic [14:0] r_irgb;
    t_word r_lzcs;
    logic [LEAD_W-1:0] r_lzcr;

    // control bank
    t_word r_mat_pair [12];   // matrix words 0..3 of each group
    t_half r_mat_last [3];    // matrix word 4 of each group
    t_word r_vec  [9];
    t_word r_ofs  [2];
    t_half r_h;
    t_half r_dqa;
    t_word r_dqb;
    t_half r_zsf  [2];
    t_word r_flag;

    logic  w_is_read;
    logic  w_adv;
    logic  w_take;
    logic  w_wr_data;
    logic  w_wr_ctrl;
    t_word w_rd_data;
    t_word w_flag_next;
    logic [LEAD_W-1:0] w_lead;

    // control bank decode
    logic [1:0] w_grp;
    logic [2:0] w_word;
    logic       w_in_group;
    logic       w_is_mat;
    logic [3:0] w_pair_sel;
    logic [3:0] w_vec_sel;

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    assign w_is_read = (r_mode == MODE_DATA_RD) || (r_mode == MODE_CTRL_RD);
    // writes always leave; reads leave when the output register frees
    assign w_adv     = r_in_valid && (!w_is_read || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_adv;
    assign w_take    = i_valid && !o_stall;
    assign w_wr_data = w_adv && (r_mode == MODE_DATA_WR);
    assign w_wr_ctrl = w_adv && (r_mode == MODE_CTRL_WR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mode <= i_mode;
            r_idx  <= i_reg_index;
            r_val  <= i_write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_is_read) begin
            r_out_data <= w_rd_data;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_data;

    // ---------------------------------------------------------------
    // side-effect logic
    // ---------------------------------------------------------------
    gcrf_lzc u_lzc (
        .i_value (r_val),
        .o_count (w_lead)
    );

    // flag keeps bits 30..12, bit 31 summarizes the error bits
    always_comb begin
        w_flag_next = r_val & FLAG_KEEP_MASK;
        if ((w_flag_next & FLAG_ERROR_MASK) != '0) begin
            w_flag_next = w_flag_next | FLAG_ERROR_BIT;
        end
    end

    // matrix / vector groups below register 24
    assign w_grp      = r_idx[4:3];
    assign w_word     = r_idx[2:0];
    assign w_in_group = (w_grp != GROUP_SCALAR);
    assign w_is_mat   = (w_word <= MAT_SINGLE_WORD);
    assign w_pair_sel = {w_grp, w_word[1:0]};
    assign w_vec_sel  = 4'({w_grp, 1'b0}) + 4'(w_grp) + 4'(w_word - VEC_FIRST_WORD);

    // ---------------------------------------------------------------
    // read mux
    // ---------------------------------------------------------------
    always_comb begin
        w_rd_data = '0;
        if (r_mode == MODE_DATA_RD) begin
            unique case (r_idx) inside
                DR_VXY0, DR_VXY1, DR_VXY2: w_rd_data = r_vxy[r_idx[2:1]];
                DR_VZ0, DR_VZ1, DR_VZ2:    w_rd_data = sext16(r_vz[r_idx[2:1]]);
                DR_RGBC:                   w_rd_data = r_rgbc;
                DR_OTZ:                    w_rd_data = {16'd0, r_otz};
                DR_IR0, DR_IR1, DR_IR2, DR_IR3:
                                           w_rd_data = sext16(r_ir[r_idx[1:0]]);
                DR_SXY0, DR_SXY1, DR_SXY2: w_rd_data = r_sxy[r_idx[1:0]];
                DR_SXYP:                   w_rd_data = r_sxy[2];
                DR_SZ0, DR_SZ1, DR_SZ2, DR_SZ3:
                                           w_rd_data = {16'd0, r_sz[r_idx[1:0]]};
                DR_RGB0, DR_RGB1, DR_RGB2: w_rd_data = r_rgb[r_idx[1:0]];
                DR_RES1:                   w_rd_data = r_res1;
                DR_MAC0, DR_MAC1, DR_MAC2, DR_MAC3:
                                           w_rd_data = r_mac[r_idx[1:0]];
                // packed color, saturated ir1..ir3 / 128
                DR_IRGB, DR_ORGB:
                    w_rd_data = {17'd0, color_field(r_ir[3]), color_field(r_ir[2]),
                                 color_field(r_ir[1])};
                DR_LZCS:                   w_rd_data = r_lzcs;
                DR_LZCR:                   w_rd_data = 32'(r_lzcr);
                default:                   w_rd_data = '0;
            endcase
        end else if (w_in_group) begin
            if (!w_is_mat) begin
                w_rd_data = r_vec[w_vec_sel];
            end else if (w_word == MAT_SINGLE_WORD) begin
                w_rd_data = sext16(r_mat_last[w_grp]);
            end else begin
                w_rd_data = r_mat_pair[w_pair_sel];
            end
        end else begin
            unique case (r_idx) inside
                CR_OFX, CR_OFY:   w_rd_data = r_ofs[r_idx[0]];
                CR_H:             w_rd_data = sext16(r_h);
                CR_DQA:           w_rd_data = sext16(r_dqa);
                CR_DQB:           w_rd_data = r_dqb;
                CR_ZSF3, CR_ZSF4: w_rd_data = sext16(r_zsf[r_idx[1]]);
                CR_FLAG:          w_rd_data = r_flag;
                default:          w_rd_data = '0;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // data bank writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vxy[i] <= '0;
                r_vz[i]  <= '0;
                r_sxy[i] <= '0;
                r_rgb[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_ir[i]  <= '0;
                r_sz[i]  <= '0;
                r_mac[i] <= '0;
            end
            r_rgbc <= '0;
            r_otz  <= '0;
            r_res1 <= '0;
            r_irgb <= '0;
            r_lzcs <= '0;
            r_lzcr <= '0;
        end else if (w_wr_data) begin
            unique case (r_idx) inside
                DR_VXY0, DR_VXY1, DR_VXY2: r_vxy[r_idx[2:1]] <= r_val;
                DR_VZ0, DR_VZ1, DR_VZ2:    r_vz[r_idx[2:1]]  <= r_val[15:0];
                DR_RGBC:                   r_rgbc <= r_val;
                DR_OTZ:                    r_otz  <= r_val[15:0];
                DR_IR0, DR_IR1, DR_IR2, DR_IR3:
                                           r_ir[r_idx[1:0]] <= r_val[15:0];
                DR_SXY0, DR_SXY1, DR_SXY2: r_sxy[r_idx[1:0]] <= r_val;
                // fifo push: shift down, new entry on top
                DR_SXYP: begin
                    r_sxy[0] <= r_sxy[1];
                    r_sxy[1] <= r_sxy[2];
                    r_sxy[2] <= r_val;
                end
                DR_SZ0, DR_SZ1, DR_SZ2, DR_SZ3:
                                           r_sz[r_idx[1:0]] <= r_val[15:0];
                DR_RGB0, DR_RGB1, DR_RGB2: r_rgb[r_idx[1:0]] <= r_val;
                DR_RES1:                   r_res1 <= r_val;
                DR_MAC0, DR_MAC1, DR_MAC2, DR_MAC3:
                                           r_mac[r_idx[1:0]] <= r_val;
                // packed color expands into ir1..ir3
                DR_IRGB: begin
                    r_irgb  <= r_val[14:0];
                    r_ir[1] <= color_expand(r_val[4:0]);
                    r_ir[2] <= color_expand(r_val[9:5]);
                    r_ir[3] <= color_expand(r_val[14:10]);
                end
                DR_LZCS: begin
                    r_lzcs <= r_val;
                    r_lzcr <= w_lead;
                end
                // orgb and lzcr are read only
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // control bank writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 12; i++) begin
                r_mat_pair[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_mat_last[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                r_vec[i] <= '0;
            end
            r_ofs[0] <= '0;
            r_ofs[1] <= '0;
            r_h      <= '0;
            r_dqa    <= '0;
            r_dqb    <= '0;
            r_zsf[0] <= '0;
            r_zsf[1] <= '0;
            r_flag   <= '0;
        end else if (w_wr_ctrl) begin
            if (w_in_group) begin
                if (!w_is_mat) begin
                    r_vec[w_vec_sel] <= r_val;
                end else if (w_word == MAT_SINGLE_WORD) begin
                    r_mat_last[w_grp] <= r_val[15:0];
                end else begin
                    r_mat_pair[w_pair_sel] <= r_val;
                end
            end else begin
                unique case (r_idx) inside
                    CR_OFX, CR_OFY:   r_ofs[r_idx[0]] <= r_val;
                    CR_H:             r_h   <= r_val[15:0];
                    CR_DQA:           r_dqa <= r_val[15:0];
                    CR_DQB:           r_dqb <= r_val;
                    CR_ZSF3, CR_ZSF4: r_zsf[r_idx[1]] <= r_val[15:0];
                    CR_FLAG:          r_flag <= w_flag_next;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
`ifndef SYNTHESIS
    // a read that leaves the input register lands in the output register
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_read) |=> r_out_valid)
        else $error("read left input register without output data");

    // the input side only stalls behind a read blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && w_is_read && r_out_valid && i_stall))
        else $error("input stalled without a blocked read");

    // leading count lands in 1..32 after an lzcs write
    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_data && r_idx == DR_LZCS) |=> (r_lzcr != '0 && r_lzcr <= LEAD_W'(32)))
        else $error("leading count out of range");

    // flag summary bit tracks the error bits, low bits stay clear
    a_flag_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flag[31] == ((r_flag & FLAG_ERROR_MASK) != '0)) && (r_flag[11:0] == 12'd0))
        else $error("flag register inconsistent");
`endif

endmodule

FILE: rtl/gcrf_lzc.sv
// leading sign-bit counter for the lzcs/lzcr pair
// depends on gcrf_pkg
module gcrf_lzc
    import gcrf_pkg::*;
(
    input  t_word             i_value,
    output logic [LEAD_W-1:0] o_count
);

    t_word             w_norm;
    logic [LEAD_W-1:0] w_cnt;

    // fold negatives so the count becomes leading zeros, bit 31 always clear
    always_comb begin
        w_norm = i_value[31] ? ~i_value : i_value;
        w_cnt  = '0;
        if (w_norm[31:16] == 16'd0) begin
            w_cnt  = w_cnt + LEAD_W'(16);
            w_norm = w_norm << 16;
        end
        if (w_norm[31:24] == 8'd0) begin
            w_cnt  = w_cnt + LEAD_W'(8);
            w_norm = w_norm << 8;
        end
        if (w_norm[31:28] == 4'd0) begin
            w_cnt  = w_cnt + LEAD_W'(4);
            w_norm = w_norm << 4;
        end
        if (w_norm[31:30] == 2'd0) begin
            w_cnt  = w_cnt + LEAD_W'(2);
            w_norm = w_norm << 2;
        end
        if (w_norm[31] == 1'b0) begin
            w_cnt  = w_cnt + LEAD_W'(1);
            w_norm = w_norm << 1;
        end
        if (w_norm[31] == 1'b0) begin
            w_cnt = w_cnt + LEAD_W'(1);
        end
    end

    assign o_count = w_cnt;

endmodule
